>>> rtl/code_point_intern_table_assert.svh
// Assertion macros for the code point intern table.
// Depends on a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef CODE_POINT_INTERN_TABLE_ASSERT_SVH
`define CODE_POINT_INTERN_TABLE_ASSERT_SVH

// Check a condition at every clock edge outside reset
`define CPIT_ASSERT(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// Check that a condition holds in the cycle after a trigger
`define CPIT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/cpit_pkg.sv
// Shared types and constants for the code point intern table.
// No dependencies; used by cpit_cell and code_point_intern_table.
package cpit_pkg;

    localparam int TABLE_ENTRIES_DEF = 1024;
    localparam int PASS_LIMIT_DEF    = 128;
    localparam int NBSP_INDEX        = 160;

    localparam int POINT_W  = 21;
    localparam int CHAR_W   = 16;
    localparam int FILL_W   = 17;
    localparam int CELLS    = 4;
    localparam int LANE_W   = $clog2(CELLS);
    localparam int ROWSEL_W = CHAR_W - LANE_W;

    typedef enum logic {
        OP_ENCODE = 1'b0,
        OP_DECODE = 1'b1
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_FULL       = 2'd1,
        ST_UNASSIGNED = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_INSERT,
        S_DONE
    } t_state;

    typedef struct packed {
        t_opcode             opcode;
        logic [POINT_W-1:0]  code_point;
        logic [CHAR_W-1:0]   char_index;
    } t_in;

    typedef struct packed {
        logic [CHAR_W-1:0]   index_out;
        logic [POINT_W-1:0]  point_out;
        t_status             status;
    } t_out;

    // One search beat travelling down the cell chain
    typedef struct packed {
        logic                valid;
        logic                last;
        logic                hit;
        logic [ROWSEL_W-1:0] row;
        logic [CHAR_W-1:0]   idx;
        logic [POINT_W-1:0]  point;
    } t_beat;

    // Per-item values that every cell sees
    typedef struct packed {
        t_opcode             op;
        logic [POINT_W-1:0]  key;
        logic [LANE_W-1:0]   lane;
        logic [FILL_W-1:0]   fill;
    } t_share;

    // Table write, steered to one cell by lane
    typedef struct packed {
        logic                en;
        logic [ROWSEL_W-1:0] row;
        logic [LANE_W-1:0]   lane;
        logic [POINT_W-1:0]  data;
    } t_wr;

endpackage

>>> rtl/cpit_cell.sv
// One cell of the search chain: a bank of the point table plus one comparator.
// Depends on cpit_pkg for beat, share and write types.
module cpit_cell #(
    parameter int TABLE_ENTRIES = cpit_pkg::TABLE_ENTRIES_DEF,
    parameter int PASS_LIMIT    = cpit_pkg::PASS_LIMIT_DEF,
    parameter int LANE          = 0
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  cpit_pkg::t_share i_share,
    input  cpit_pkg::t_wr    i_wr,
    input  cpit_pkg::t_beat  i_beat,
    output cpit_pkg::t_beat  o_beat
);

    localparam int ROWS  = (TABLE_ENTRIES + cpit_pkg::CELLS - 1) / cpit_pkg::CELLS;
    localparam int ROW_W = $clog2(ROWS);
    localparam int IDX_W = ROW_W + cpit_pkg::LANE_W;

    logic [cpit_pkg::POINT_W-1:0] mem [ROWS];
    logic [cpit_pkg::POINT_W-1:0] r_rd;
    cpit_pkg::t_beat              r_beat;
    logic [IDX_W-1:0]             w_eidx;
    logic                         w_live;
    logic                         w_lane_sel;

    // Write this bank's entries
    always_ff @(posedge i_clk) begin
        if (i_wr.en && (i_wr.lane == cpit_pkg::LANE_W'(LANE))) begin
            mem[i_wr.row[ROW_W-1:0]] <= i_wr.data;
        end
    end

    // Read the row of the incoming beat and hold the beat alongside
    always_ff @(posedge i_clk) begin
        r_rd <= mem[i_beat.row[ROW_W-1:0]];
        if (!i_rst_n) begin
            r_beat <= '0;
        end else begin
            r_beat <= i_beat;
        end
    end

    // Entry is searchable when assigned and not the reserved slot
    assign w_eidx     = {r_beat.row[ROW_W-1:0], cpit_pkg::LANE_W'(LANE)};
    assign w_live     = (w_eidx >= IDX_W'(PASS_LIMIT))
                     && ({1'b0, w_eidx} < i_share.fill[IDX_W:0])
                     && (w_eidx != IDX_W'(cpit_pkg::NBSP_INDEX));
    assign w_lane_sel = (i_share.lane == cpit_pkg::LANE_W'(LANE));

    // Merge this cell's match into the beat and hand it on
    always_comb begin
        o_beat = r_beat;
        if (r_beat.valid && !r_beat.hit) begin
            if (i_share.op == cpit_pkg::OP_DECODE) begin
                if (w_lane_sel) begin
                    o_beat.hit   = 1'b1;
                    o_beat.point = r_rd;
                end
            end else if (w_live && (r_rd == i_share.key)) begin
                o_beat.hit = 1'b1;
                o_beat.idx = cpit_pkg::CHAR_W'(w_eidx);
            end
        end
    end

endmodule

>>> rtl/code_point_intern_table.sv
// Flow: pass-through and unassigned-index items go from accept straight to the result stage;
// decode lookups send the one addressed row through the chain; encode scans the rows from
// PASS_LIMIT to the last filled entry, one table row entering the chain per cycle, then inserts on a miss.
// Throughput: one item at a time; the next is accepted once the result is registered.
// Reset: synchronous active low; fill count returns to PASS_LIMIT, the table keeps
// its contents (undefined until written) and gets no clearing pass.
module code_point_intern_table #(
    parameter int TABLE_ENTRIES = cpit_pkg::TABLE_ENTRIES_DEF,
    parameter int PASS_LIMIT    = cpit_pkg::PASS_LIMIT_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  cpit_pkg::t_in  i_in,
    output logic           o_in_stall,
    output logic           o_out_valid,
    output cpit_pkg::t_out o_out,
    input  logic           i_out_stall
);

    `include "code_point_intern_table_assert.svh"

    localparam int ROWS   = (TABLE_ENTRIES + cpit_pkg::CELLS - 1) / cpit_pkg::CELLS;
    localparam int ROW_W  = $clog2(ROWS);
    localparam int IDX_W  = ROW_W + cpit_pkg::LANE_W;
    localparam int FILL_W = cpit_pkg::FILL_W;
    localparam logic [ROW_W-1:0] START_ROW = ROW_W'(PASS_LIMIT >> cpit_pkg::LANE_W);

    cpit_pkg::t_state             r_state, n_state;
    cpit_pkg::t_opcode            r_op, n_op;
    logic [cpit_pkg::POINT_W-1:0] r_key, n_key;
    logic [cpit_pkg::CHAR_W-1:0]  r_idx, n_idx;
    logic [FILL_W-1:0]            r_fill, n_fill;
    logic [ROW_W-1:0]             r_row, n_row;
    logic [ROW_W-1:0]             r_last_row, n_last_row;
    logic                         r_hit, n_hit;
    cpit_pkg::t_out               r_res, n_res;
    logic                         r_out_valid, n_out_valid;
    cpit_pkg::t_out               r_out, n_out;

    logic [FILL_W-1:0]            w_fill_m1;
    logic [FILL_W-1:0]            w_slot;
    cpit_pkg::t_beat              w_head;
    cpit_pkg::t_beat              w_tail;
    cpit_pkg::t_share             w_share;
    cpit_pkg::t_wr                w_wr;
    cpit_pkg::t_beat              w_chain [cpit_pkg::CELLS+1];

    assign o_in_stall  = (r_state != cpit_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign w_fill_m1 = r_fill - FILL_W'(1);
    assign w_slot    = (r_fill == FILL_W'(cpit_pkg::NBSP_INDEX)) ? (r_fill + FILL_W'(1)) : r_fill;
    assign w_share   = '{op: r_op, key: r_key, lane: r_idx[cpit_pkg::LANE_W-1:0], fill: r_fill};

    // Search chain: one bank and comparator per cell
    assign w_chain[0] = w_head;
    assign w_tail     = w_chain[cpit_pkg::CELLS];

    for (genvar k = 0; k < cpit_pkg::CELLS; k++) begin : g_cell
        cpit_cell #(
            .TABLE_ENTRIES (TABLE_ENTRIES),
            .PASS_LIMIT    (PASS_LIMIT),
            .LANE          (k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_share (w_share),
            .i_wr    (w_wr),
            .i_beat  (w_chain[k]),
            .o_beat  (w_chain[k+1])
        );
    end

    // State and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cpit_pkg::S_IDLE;
            r_fill      <= FILL_W'(PASS_LIMIT);
            r_hit       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_hit       <= n_hit;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_key      <= n_key;
        r_idx      <= n_idx;
        r_row      <= n_row;
        r_last_row <= n_last_row;
        r_res      <= n_res;
        r_out      <= n_out;
    end

    // Next state, chain feed, table write and result assembly
    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_key       = r_key;
        n_idx       = r_idx;
        n_fill      = r_fill;
        n_row       = r_row;
        n_last_row  = r_last_row;
        n_hit       = r_hit;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        w_head      = '0;
        w_wr        = '0;

        // Drop the output beat once taken
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        // Collect a match leaving the chain
        if ((r_state == cpit_pkg::S_SCAN || r_state == cpit_pkg::S_DRAIN)
                && w_tail.valid) begin
            if (w_tail.hit && !r_hit) begin
                n_hit = 1'b1;
                if (r_op == cpit_pkg::OP_DECODE) begin
                    n_res.point_out = w_tail.point;
                end else begin
                    n_res.index_out = w_tail.idx;
                end
            end
        end

        case (r_state)
            cpit_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_op       = i_in.opcode;
                    n_key      = i_in.code_point;
                    n_idx      = i_in.char_index;
                    n_hit      = 1'b0;
                    n_res      = '0;
                    n_row      = START_ROW;
                    n_last_row = w_fill_m1[IDX_W-1:cpit_pkg::LANE_W];
                    if (i_in.opcode == cpit_pkg::OP_ENCODE) begin
                        if ((i_in.code_point < cpit_pkg::POINT_W'(PASS_LIMIT))
                                || (i_in.code_point
                                    == cpit_pkg::POINT_W'(cpit_pkg::NBSP_INDEX))) begin
                            n_res.index_out = i_in.code_point[cpit_pkg::CHAR_W-1:0];
                            n_state         = cpit_pkg::S_DONE;
                        end else begin
                            n_state = cpit_pkg::S_SCAN;
                        end
                    end else begin
                        if ((i_in.char_index < cpit_pkg::CHAR_W'(PASS_LIMIT))
                                || (i_in.char_index
                                    == cpit_pkg::CHAR_W'(cpit_pkg::NBSP_INDEX))) begin
                            n_res.point_out = cpit_pkg::POINT_W'(i_in.char_index);
                            n_state         = cpit_pkg::S_DONE;
                        end else if ({1'b0, i_in.char_index} < r_fill) begin
                            // Single-row lookup through the chain
                            n_row      = i_in.char_index[IDX_W-1:cpit_pkg::LANE_W];
                            n_last_row = i_in.char_index[IDX_W-1:cpit_pkg::LANE_W];
                            n_state    = cpit_pkg::S_SCAN;
                        end else begin
                            n_res.status = cpit_pkg::ST_UNASSIGNED;
                            n_state      = cpit_pkg::S_DONE;
                        end
                    end
                end
            end

            cpit_pkg::S_SCAN: begin
                // Feed one table row into the chain per cycle
                w_head.valid = 1'b1;
                w_head.last  = (r_row >= r_last_row);
                w_head.row   = cpit_pkg::ROWSEL_W'(r_row);
                if (r_row >= r_last_row) begin
                    n_state = cpit_pkg::S_DRAIN;
                end else begin
                    n_row = r_row + ROW_W'(1);
                end
            end

            cpit_pkg::S_DRAIN: begin
                // Wait for the final row to leave the chain
                if (w_tail.valid && w_tail.last) begin
                    if (r_hit || w_tail.hit || (r_op == cpit_pkg::OP_DECODE)) begin
                        n_state = cpit_pkg::S_DONE;
                    end else begin
                        n_state = cpit_pkg::S_INSERT;
                    end
                end
            end

            cpit_pkg::S_INSERT: begin
                // Append on a miss, or report a full table
                if (w_slot >= FILL_W'(TABLE_ENTRIES)) begin
                    n_res.index_out = '0;
                    n_res.status    = cpit_pkg::ST_FULL;
                end else begin
                    w_wr.en         = 1'b1;
                    w_wr.row        = cpit_pkg::ROWSEL_W'(w_slot[IDX_W-1:cpit_pkg::LANE_W]);
                    w_wr.lane       = w_slot[cpit_pkg::LANE_W-1:0];
                    w_wr.data       = r_key;
                    n_fill          = w_slot + FILL_W'(1);
                    n_res.index_out = w_slot[cpit_pkg::CHAR_W-1:0];
                end
                n_state = cpit_pkg::S_DONE;
            end

            cpit_pkg::S_DONE: begin
                // Move the result into the output register when it is free
                if (!r_out_valid || !i_out_stall) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = cpit_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = cpit_pkg::S_IDLE;
            end
        endcase
    end

    // Fill count stays inside the assignable range
    `CPIT_ASSERT(a_fill_range, (r_fill >= FILL_W'(PASS_LIMIT)) && (r_fill <= FILL_W'(TABLE_ENTRIES)), "fill count out of range")
    // Inserts never target the reserved slot or run past the table
    `CPIT_ASSERT(a_wr_slot, !w_wr.en || ((w_slot != FILL_W'(cpit_pkg::NBSP_INDEX)) && (w_slot < FILL_W'(TABLE_ENTRIES))), "table write to an illegal slot")
    // Beats leave the chain only while a search is running
    `CPIT_ASSERT(a_tail_busy, !w_tail.valid || (r_state == cpit_pkg::S_SCAN) || (r_state == cpit_pkg::S_DRAIN), "chain beat outside a search")
    // A finished item reaches the output register and frees the input
    `CPIT_ASSERT_NEXT(a_done_out, (r_state == cpit_pkg::S_DONE) && !(r_out_valid && i_out_stall), r_out_valid && (r_state == cpit_pkg::S_IDLE), "result not delivered")

endmodule
